// File: design/lcv_pkg.sv
// lcv_pkg: shared types, constants and command codes of the limit-cycle velocity block
// no dependencies; imported by limit_cycle_velocity_2d, lcv_ctrl and lcv_dp
`timescale 1ns / 1ps

package lcv_pkg;

	localparam int DATA_WIDTH_DEF = 40;
	localparam int FRAC_BITS      = 32;
	localparam int WEIGHT_W       = FRAC_BITS + 1;
	localparam int CFG_IDX_W      = 3;

	// register reset values, truncated to the configured widths where used
	localparam logic [63:0] RATE_RST   = 64'hFFFF_FFFF_9999_999A;
	localparam logic [63:0] GAIN_RST   = 64'd429496729600;
	localparam logic [63:0] LIMIT_RST  = 64'd429496730;
	localparam logic [63:0] WEIGHT_RST = 64'd214748365;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGULAR_RATE  = 3'd0,
		REG_VELOCITY_GAIN = 3'd1,
		REG_SPEED_LIMIT   = 3'd2,
		REG_FILTER_WEIGHT = 3'd3
	} cfg_reg_t;

	// datapath micro-operations, in issue order
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_MUL_XX,
		CMD_MUL_YY,
		CMD_SQRT_R,
		CMD_DIV_C,
		CMD_DIV_S,
		CMD_UNIT,
		CMD_ERR,
		CMD_MUL_EC,
		CMD_MUL_RY,
		CMD_MUL_ES,
		CMD_MUL_RX,
		CMD_MUL_GX,
		CMD_MUL_GY,
		CMD_MUL_VXX,
		CMD_MUL_VYY,
		CMD_SQRT_N,
		CMD_MUL_VXL,
		CMD_DIV_VX,
		CMD_MUL_VYL,
		CMD_DIV_VY,
		CMD_MUL_WX,
		CMD_MUL_CFX,
		CMD_MUL_WY,
		CMD_MUL_CFY
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		cmd_t op;
		logic start;
		logic load;
		logic out_load;
	} dp_ctrl_t;

	typedef struct packed {
		logic done;
		logic zero;
		logic clamped;
	} dp_stat_t;

	function automatic logic cmd_is_sqrt(input cmd_t c);
		return (c == CMD_SQRT_R) || (c == CMD_SQRT_N);
	endfunction

	function automatic logic cmd_is_div(input cmd_t c);
		return (c == CMD_DIV_C) || (c == CMD_DIV_S) || (c == CMD_DIV_VX) || (c == CMD_DIV_VY);
	endfunction

	function automatic logic cmd_is_mul(input cmd_t c);
		return !cmd_is_sqrt(c) && !cmd_is_div(c) && (c != CMD_NONE) && (c != CMD_UNIT)
			&& (c != CMD_ERR);
	endfunction

endpackage

// File: design/limit_cycle_velocity_2d.sv
// limit_cycle_velocity_2d: one sample of a planar circular limit-cycle velocity, filtered
// this is the top level; it depends on lcv_pkg, lcv_ctrl and lcv_dp
//
// Each input transaction (offset pos_x/pos_y, signed fixed point with 32 fraction bits, and an unsigned
// target radius with 32 fraction bits) yields exactly one output transaction: the velocity that pulls the offset onto
// a circle of the target radius while turning at angular_rate, scaled by velocity_gain, clamped
// in magnitude to speed_limit (was_clamped flags it) and blended into the stored filtered
// velocity with filter_weight. Every intermediate saturates to the DATA_WIDTH signed range.
// One transaction is worked on at a time. It goes through a shared bit-serial multiplier
// and a shared divider / square root unit, both MW = max(DATA_WIDTH, 33) bits wide, one
// operation after another; the clamp operations are skipped when the speed limit is not hit,
// and the radius square root and the divisions by it are skipped when the offset is zero.
// The finished result sits in an output register, so a new transaction is taken while it waits.
// Configuration writes are always accepted and should only be issued while the block is idle.
`timescale 1ns / 1ps

module limit_cycle_velocity_2d #(
	parameter int DATA_WIDTH = lcv_pkg::DATA_WIDTH_DEF,
	localparam int MW = (DATA_WIDTH > lcv_pkg::WEIGHT_W) ? DATA_WIDTH : lcv_pkg::WEIGHT_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input transactions
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [DATA_WIDTH-1:0]         pos_x,
	input  logic [DATA_WIDTH-1:0]         pos_y,
	input  logic [DATA_WIDTH-2:0]         target_radius,
	// output transactions
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DATA_WIDTH-1:0]         vel_x,
	output logic [DATA_WIDTH-1:0]         vel_y,
	output logic                          was_clamped,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lcv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [MW-1:0]                 cfg_data
);
	import lcv_pkg::*;

	dp_ctrl_t ctl;
	dp_stat_t stat;

	// registers are plain flops, a write never stalls
	assign cfg_ready = 1'b1;

	// sequencer: walks the operation list, holds the handshakes
	lcv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	// datapath: arithmetic units, working registers, filter state, output register
	lcv_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.MW         (MW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.target_radius (target_radius),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.was_clamped   (was_clamped)
	);

`ifndef SYNTHESIS
	// one transaction at a time: no second accept right behind the first
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// an operation only completes while a transaction is being worked on
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> !in_ready)
		else $error("datapath completion while idle");

	// a result is never written over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");
`endif

endmodule

// File: design/lcv_mul.sv
// lcv_mul: shift-and-add multiplier, one operand bit per cycle, full-width product
// depends on nothing but its parameter
`timescale 1ns / 1ps

module lcv_mul #(
	parameter int MW = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic            done,
	output logic [2*MW-1:0] prod
);
	localparam int CW = $clog2(MW + 1);

	logic [MW-1:0] hi_q, lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [MW:0]   sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a} : '0);
	assign prod = {hi_q, lo_q};
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(MW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MW:1];
			lo_q <= {sum[0], lo_q[MW-1:1]};
		end
	end

endmodule

// File: design/lcv_dsq.sv
// lcv_dsq: restoring divider and square root sharing one shift register
// depends on nothing but its parameter; a quotient bit or a root bit per cycle
`timescale 1ns / 1ps

module lcv_dsq #(
	parameter int MW = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            mode_sqrt,
	input  logic [2*MW-1:0] num,
	input  logic [MW-1:0]   den,
	output logic            done,
	output logic [2*MW-1:0] quo,
	output logic [MW-1:0]   root
);
	localparam int NW = 2 * MW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [MW:0]   rem_q;
	logic [MW-1:0] root_q;
	logic [MW-1:0] den_q;
	logic          mode_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	logic [MW:0]   dt, dsub;
	logic          dge;
	logic [MW+2:0] st, strial, ssub;
	logic          sge;

	// division step
	assign dt   = {rem_q[MW-1:0], num_q[NW-1]};
	assign dge  = dt >= {1'b0, den_q};
	assign dsub = dt - {1'b0, den_q};
	// square root step
	assign st     = {rem_q, num_q[NW-1:NW-2]};
	assign strial = {1'b0, root_q, 2'b01};
	assign sge    = st >= strial;
	assign ssub   = st - strial;

	assign quo  = num_q;
	assign root = root_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= mode_sqrt ? CW'(MW) : CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			rem_q  <= '0;
			root_q <= '0;
			den_q  <= den;
			mode_q <= mode_sqrt;
		end else if (busy_q) begin
			if (mode_q) begin
				rem_q  <= sge ? ssub[MW:0] : st[MW:0];
				root_q <= {root_q[MW-2:0], sge};
				num_q  <= {num_q[NW-3:0], 2'b00};
			end else begin
				rem_q <= {1'b0, (dge ? dsub[MW-1:0] : dt[MW-1:0])};
				num_q <= {num_q[NW-2:0], dge};
			end
		end
	end

endmodule

// File: design/lcv_dp.sv
// lcv_dp: datapath of the limit-cycle velocity block: registers, operand selection, saturation
// depends on lcv_pkg, lcv_mul and lcv_dsq
`timescale 1ns / 1ps

module lcv_dp #(
	parameter int DATA_WIDTH = 40,
	parameter int MW = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lcv_pkg::dp_ctrl_t                 ctl,
	output lcv_pkg::dp_stat_t                 stat,
	input  logic [DATA_WIDTH-1:0]             pos_x,
	input  logic [DATA_WIDTH-1:0]             pos_y,
	input  logic [DATA_WIDTH-2:0]             target_radius,
	input  logic                              cfg_we,
	input  logic [lcv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [MW-1:0]                     cfg_data,
	output logic [DATA_WIDTH-1:0]             vel_x,
	output logic [DATA_WIDTH-1:0]             vel_y,
	output logic                              was_clamped
);
	import lcv_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int SW = MW + 1;
	localparam int NW = 2 * MW;
	localparam logic [SW-1:0] MAXPOS = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [SW-1:0] MINNEG = ~MAXPOS;
	localparam logic [SW-1:0] ONE_Q  = {{(SW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	function automatic logic [SW-1:0] sat(input logic neg, input logic [NW-1:0] m);
		logic [NW-1:0] mx;
		logic [SW-1:0] r;
		mx = {{(NW-SW){1'b0}}, MAXPOS};
		if (!neg)
			r = (m > mx) ? MAXPOS : m[SW-1:0];
		else if (m == '0)
			r = '0;
		else if (m > mx)
			r = MINNEG;
		else
			r = -m[SW-1:0];
		return r;
	endfunction

	function automatic logic [MW-1:0] mag(input logic [SW-1:0] v);
		logic [SW-1:0] t;
		t = v[SW-1] ? -v : v;
		return t[MW-1:0];
	endfunction

	function automatic logic [SW-1:0] sadd(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic signed [SW:0] s;
		s = $signed({a[SW-1], a}) + $signed({b[SW-1], b});
		if (s > $signed({1'b0, MAXPOS}))
			return MAXPOS;
		else if (s < $signed({1'b1, MINNEG}))
			return MINNEG;
		else
			return s[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] sneg(input logic [SW-1:0] a);
		return (a == MINNEG) ? MAXPOS : -a;
	endfunction

	// item registers
	logic [SW-1:0] x_q, y_q, c_q, s_q, e_q, t1_q, dx_q, dy_q, vx_q, vy_q;
	logic [MW-1:0] r_q, norm_q;
	logic [W-2:0]  rad_q;
	logic [NW-1:0] acc_q;
	logic          clamped_q;
	// state and configuration
	logic [SW-1:0] fx_q, fy_q, rate_q;
	logic [W-2:0]  gain_q, limit_q;
	logic [WEIGHT_W-1:0] fw_q;
	logic          simple_done_q;
	// output register
	logic [W-1:0]  vel_x_q, vel_y_q;
	logic          was_clamped_q;

	logic [SW-1:0] opa, opb, prod_s, w_s, wc_s;
	logic          mul_neg;
	logic [NW-1:0] prod, dnum, quo;
	logic [MW-1:0] dden, root;
	logic          mul_done, dsq_done, unit_done, is_simple;

	assign w_s  = (SW'(fw_q) > ONE_Q) ? ONE_Q : SW'(fw_q);
	assign wc_s = ONE_Q - w_s;

	always_comb begin
		opa = '0;
		opb = '0;
		case (ctl.op)
			CMD_MUL_XX:  begin opa = x_q; opb = x_q; end
			CMD_MUL_YY:  begin opa = y_q; opb = y_q; end
			CMD_MUL_EC:  begin opa = e_q; opb = c_q; end
			CMD_MUL_RY:  begin opa = rate_q; opb = y_q; end
			CMD_MUL_ES:  begin opa = e_q; opb = s_q; end
			CMD_MUL_RX:  begin opa = rate_q; opb = x_q; end
			CMD_MUL_GX:  begin opa = SW'(gain_q); opb = dx_q; end
			CMD_MUL_GY:  begin opa = SW'(gain_q); opb = dy_q; end
			CMD_MUL_VXX: begin opa = vx_q; opb = vx_q; end
			CMD_MUL_VYY: begin opa = vy_q; opb = vy_q; end
			CMD_MUL_VXL: begin opa = vx_q; opb = SW'(limit_q); end
			CMD_MUL_VYL: begin opa = vy_q; opb = SW'(limit_q); end
			CMD_MUL_WX:  begin opa = w_s; opb = vx_q; end
			CMD_MUL_CFX: begin opa = wc_s; opb = fx_q; end
			CMD_MUL_WY:  begin opa = w_s; opb = vy_q; end
			CMD_MUL_CFY: begin opa = wc_s; opb = fy_q; end
			default:     begin opa = '0; opb = '0; end
		endcase
	end

	assign mul_neg = opa[SW-1] ^ opb[SW-1];
	assign prod_s  = sat(mul_neg, prod >> FRAC_BITS);

	always_comb begin
		dnum = acc_q;
		dden = norm_q;
		case (ctl.op)
			CMD_DIV_C: begin dnum = NW'(mag(x_q)) << FRAC_BITS; dden = r_q; end
			CMD_DIV_S: begin dnum = NW'(mag(y_q)) << FRAC_BITS; dden = r_q; end
			default:   begin dnum = acc_q; dden = norm_q; end
		endcase
	end

	lcv_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start && cmd_is_mul(ctl.op)),
		.a      (mag(opa)),
		.b      (mag(opb)),
		.done   (mul_done),
		.prod   (prod)
	);

	lcv_dsq #(.MW(MW)) u_dsq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.start && (cmd_is_div(ctl.op) || cmd_is_sqrt(ctl.op))),
		.mode_sqrt (cmd_is_sqrt(ctl.op)),
		.num       (dnum),
		.den       (dden),
		.done      (dsq_done),
		.quo       (quo),
		.root      (root)
	);

	assign unit_done = mul_done || dsq_done;
	assign is_simple = (ctl.op == CMD_UNIT) || (ctl.op == CMD_ERR);

	assign stat.done    = unit_done || simple_done_q;
	assign stat.zero    = (x_q == '0) && (y_q == '0);
	assign stat.clamped = clamped_q;

	assign vel_x       = vel_x_q;
	assign vel_y       = vel_y_q;
	assign was_clamped = was_clamped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q        <= {{(SW-W){RATE_RST[W-1]}}, RATE_RST[W-1:0]};
			gain_q        <= GAIN_RST[W-2:0];
			limit_q       <= LIMIT_RST[W-2:0];
			fw_q          <= WEIGHT_RST[WEIGHT_W-1:0];
			fx_q          <= '0;
			fy_q          <= '0;
			simple_done_q <= 1'b0;
		end else begin
			simple_done_q <= ctl.start && is_simple;
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGULAR_RATE:  rate_q  <= {{(SW-W){cfg_data[W-1]}}, cfg_data[W-1:0]};
					REG_VELOCITY_GAIN: gain_q  <= cfg_data[W-2:0];
					REG_SPEED_LIMIT:   limit_q <= cfg_data[W-2:0];
					REG_FILTER_WEIGHT: fw_q    <= cfg_data[WEIGHT_W-1:0];
					default:           ;
				endcase
			end
			if (mul_done && (ctl.op == CMD_MUL_CFX))
				fx_q <= sadd(t1_q, prod_s);
			if (mul_done && (ctl.op == CMD_MUL_CFY))
				fy_q <= sadd(t1_q, prod_s);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q   <= {{(SW-W){pos_x[W-1]}}, pos_x};
			y_q   <= {{(SW-W){pos_y[W-1]}}, pos_y};
			rad_q <= target_radius;
		end
		if (ctl.start && (ctl.op == CMD_UNIT)) begin
			r_q <= '0;
			c_q <= ONE_Q;
			s_q <= '0;
		end
		if (ctl.start && (ctl.op == CMD_ERR)) begin
			if (r_q > MW'(rad_q))
				e_q <= sat(1'b1, NW'(r_q - MW'(rad_q)));
			else
				e_q <= sat(1'b0, NW'(MW'(rad_q) - r_q));
		end
		if (unit_done) begin
			case (ctl.op)
				CMD_MUL_XX:  acc_q <= prod;
				CMD_MUL_YY:  acc_q <= acc_q + prod;
				CMD_SQRT_R:  r_q <= root;
				CMD_DIV_C:   c_q <= sat(x_q[SW-1], quo);
				CMD_DIV_S:   s_q <= sat(y_q[SW-1], quo);
				CMD_MUL_EC:  t1_q <= prod_s;
				CMD_MUL_RY:  dx_q <= sadd(t1_q, sneg(prod_s));
				CMD_MUL_ES:  t1_q <= prod_s;
				CMD_MUL_RX:  dy_q <= sadd(t1_q, prod_s);
				CMD_MUL_GX:  vx_q <= prod_s;
				CMD_MUL_GY:  vy_q <= prod_s;
				CMD_MUL_VXX: acc_q <= prod;
				CMD_MUL_VYY: acc_q <= acc_q + prod;
				CMD_SQRT_N: begin
					norm_q    <= root;
					clamped_q <= root > MW'(limit_q);
				end
				CMD_MUL_VXL: acc_q <= prod;
				CMD_DIV_VX:  vx_q <= sat(vx_q[SW-1], quo);
				CMD_MUL_VYL: acc_q <= prod;
				CMD_DIV_VY:  vy_q <= sat(vy_q[SW-1], quo);
				CMD_MUL_WX:  t1_q <= prod_s;
				CMD_MUL_WY:  t1_q <= prod_s;
				default:     ;
			endcase
		end
		if (ctl.out_load) begin
			vel_x_q       <= fx_q[W-1:0];
			vel_y_q       <= fy_q[W-1:0];
			was_clamped_q <= clamped_q;
		end
	end

endmodule

// File: design/lcv_ctrl.sv
// lcv_ctrl: sequencer of the limit-cycle velocity block, issues one datapath operation at a time
// depends on lcv_pkg
`timescale 1ns / 1ps

module lcv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lcv_pkg::dp_ctrl_t ctl,
	input  lcv_pkg::dp_stat_t stat
);
	import lcv_pkg::*;

	ctrl_state_t state_q, state_n;
	cmd_t        step_q, step_n;
	logic        out_valid_q;

	function automatic cmd_t next_cmd(input cmd_t c, input logic zero, input logic clamped);
		cmd_t n;
		case (c)
			CMD_NONE:    n = zero ? CMD_UNIT : CMD_MUL_XX;
			CMD_MUL_XX:  n = CMD_MUL_YY;
			CMD_MUL_YY:  n = CMD_SQRT_R;
			CMD_SQRT_R:  n = CMD_DIV_C;
			CMD_DIV_C:   n = CMD_DIV_S;
			CMD_DIV_S:   n = CMD_ERR;
			CMD_UNIT:    n = CMD_ERR;
			CMD_ERR:     n = CMD_MUL_EC;
			CMD_MUL_EC:  n = CMD_MUL_RY;
			CMD_MUL_RY:  n = CMD_MUL_ES;
			CMD_MUL_ES:  n = CMD_MUL_RX;
			CMD_MUL_RX:  n = CMD_MUL_GX;
			CMD_MUL_GX:  n = CMD_MUL_GY;
			CMD_MUL_GY:  n = CMD_MUL_VXX;
			CMD_MUL_VXX: n = CMD_MUL_VYY;
			CMD_MUL_VYY: n = CMD_SQRT_N;
			CMD_SQRT_N:  n = clamped ? CMD_MUL_VXL : CMD_MUL_WX;
			CMD_MUL_VXL: n = CMD_DIV_VX;
			CMD_DIV_VX:  n = CMD_MUL_VYL;
			CMD_MUL_VYL: n = CMD_DIV_VY;
			CMD_DIV_VY:  n = CMD_MUL_WX;
			CMD_MUL_WX:  n = CMD_MUL_CFX;
			CMD_MUL_CFX: n = CMD_MUL_WY;
			CMD_MUL_WY:  n = CMD_MUL_CFY;
			default:     n = CMD_NONE;
		endcase
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= CMD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n      = state_q;
		step_n       = step_q;
		in_ready     = 1'b0;
		ctl.op       = step_q;
		ctl.start    = 1'b0;
		ctl.load     = 1'b0;
		ctl.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					step_n   = CMD_NONE;
					state_n  = ST_ADV;
				end
			end
			ST_ADV: begin
				if (step_q == CMD_MUL_CFY)
					state_n = ST_DONE;
				else begin
					step_n  = next_cmd(step_q, stat.zero, stat.clamped);
					state_n = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				ctl.start = 1'b1;
				state_n   = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.done)
					state_n = ST_ADV;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
